[hw/rtl/chacha20_stream_cipher_macros.svh]
// Assertion macros for the ChaCha20 stream cipher checker.
// Included by cc20_checker.sv; no other dependencies.
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CC20_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CC20_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cc20_pkg.sv]
// Shared types and constants for the ChaCha20 stream cipher.
// No dependencies; used by cc20_core, the top level and the testbench.
package cc20_pkg;

    localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
    localparam int unsigned BLOCK_BYTES       = 64;
    localparam int unsigned CFG_IDX_W         = 3;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_GEN,
        ST_OUT
    } state_t;

    // block generation request to the round core
    typedef struct packed {
        logic         start;
        logic [31:0]  counter;
        logic [255:0] key;
        logic [95:0]  nonce;
    } core_req_t;

    // finished keystream block from the round core
    typedef struct packed {
        logic         done;
        logic [511:0] block;
    } core_rsp_t;

endpackage

[hw/rtl/cc20_qr.sv]
// One quarter-round lane: half a quarter round per cycle, phase selects which half.
// Depends on nothing outside this file.
module cc20_qr
(
    input  logic        phase,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    output logic [31:0] a_out,
    output logic [31:0] b_out,
    output logic [31:0] c_out,
    output logic [31:0] d_out
);

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    logic [31:0] dx;
    logic [31:0] bx;

    always_comb
    begin
        a_out = a + b;
        dx    = d ^ a_out;
        d_out = phase ? rotl(dx, 8) : rotl(dx, 16);
        c_out = c + d_out;
        bx    = b ^ c_out;
        b_out = phase ? rotl(bx, 7) : rotl(bx, 12);
    end

endmodule

[hw/rtl/cc20_core.sv]
// Keystream block generator: four quarter-round lanes over the 16 state words,
// then the merge of the initial state. Depends on cc20_pkg and cc20_qr.
module cc20_core
#(
    parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cc20_pkg::core_req_t req,
    output cc20_pkg::core_rsp_t rsp
);

    // column half 0, column half 1, diagonal half 0, diagonal half 1
    localparam int unsigned STEPS  = DOUBLE_ROUNDS * 4;
    localparam int unsigned STEP_W = $clog2(STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    logic [31:0] words_reg [16];
    logic [31:0] words_next [16];
    logic [31:0] init_reg [16];
    logic [31:0] init_w [16];
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [31:0] la [4];
    logic [31:0] lb [4];
    logic [31:0] lc [4];
    logic [31:0] ld [4];
    logic [31:0] oa [4];
    logic [31:0] ob [4];
    logic [31:0] oc [4];
    logic [31:0] od [4];

    logic diag;
    assign diag = step_reg[1];

    always_comb
    begin
        init_w[0] = cc20_pkg::SIGMA_0;
        init_w[1] = cc20_pkg::SIGMA_1;
        init_w[2] = cc20_pkg::SIGMA_2;
        init_w[3] = cc20_pkg::SIGMA_3;
        for (int i = 0; i < 4; i++)
        begin
            init_w[4 + 2 * i] = req.key[64 * i +: 32];
            init_w[5 + 2 * i] = req.key[64 * i + 32 +: 32];
        end
        init_w[12] = req.counter;
        init_w[13] = req.nonce[31:0];
        init_w[14] = req.nonce[63:32];
        init_w[15] = req.nonce[95:64];
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        assign la[k] = words_reg[k];
        assign lb[k] = diag ? words_reg[4 + ((k + 1) & 3)]  : words_reg[4 + k];
        assign lc[k] = diag ? words_reg[8 + ((k + 2) & 3)]  : words_reg[8 + k];
        assign ld[k] = diag ? words_reg[12 + ((k + 3) & 3)] : words_reg[12 + k];

        cc20_qr u_qr
        (
            .phase (step_reg[0]),
            .a     (la[k]),
            .b     (lb[k]),
            .c     (lc[k]),
            .d     (ld[k]),
            .a_out (oa[k]),
            .b_out (ob[k]),
            .c_out (oc[k]),
            .d_out (od[k])
        );
    end

    always_comb
    begin
        words_next = words_reg;
        busy_next  = busy_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            words_next = init_w;
            busy_next  = 1'b1;
            step_next  = '0;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                words_next[k] = oa[k];
                if (diag)
                begin
                    words_next[4 + ((k + 1) & 3)]  = ob[k];
                    words_next[8 + ((k + 2) & 3)]  = oc[k];
                    words_next[12 + ((k + 3) & 3)] = od[k];
                end
                else
                begin
                    words_next[4 + k]  = ob[k];
                    words_next[8 + k]  = oc[k];
                    words_next[12 + k] = od[k];
                end
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // round words and initial state are payload: no reset
    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
        if (req.start)
        begin
            init_reg <= init_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // merge: add the initial state back, word by word
    always_comb
    begin
        rsp.done = done_reg;
        for (int i = 0; i < 16; i++)
        begin
            rsp.block[32 * i +: 32] = words_reg[i] + init_reg[i];
        end
    end

endmodule

[hw/rtl/chacha20_stream_cipher.sv]
// Top level of the ChaCha20 (IETF, 96-bit nonce) stream cipher.
// Depends on cc20_pkg, cc20_core and cc20_qr.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  config  | cfg_we, cfg_index, cfg_data               | in
//  input   | in_valid/in_stall, data_in, byte_count,   | in
//          | last_in                                   |
//  output  | out_valid/out_stall, data_out,            | out
//          | byte_count_out, last_out                  |
//
// A request inside the current keystream block goes through accept, apply, count
// check and result register; an empty one skips the apply, one crossing a block
// adds a second apply. Each new 64-byte block is made by the four quarter-round
// lanes, each doing half a quarter round per cycle. Reset clears all control
// state; there is no clearing pass. The result register lets a new request in
// while the last result waits under out_stall.
module chacha20_stream_cipher
#(
    parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [63:0]                   data_in,
    input  logic [3:0]                    byte_count,
    input  logic                          last_in,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [63:0]                   data_out,
    output logic [3:0]                    byte_count_out,
    output logic                          last_out
);

    // --------------------------------------------------------------
    // Configuration registers
    // --------------------------------------------------------------
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cc20_pkg::CFG_KEY_PART_0: key0_reg     <= cfg_data;
                cc20_pkg::CFG_KEY_PART_1: key1_reg     <= cfg_data;
                cc20_pkg::CFG_KEY_PART_2: key2_reg     <= cfg_data;
                cc20_pkg::CFG_KEY_PART_3: key3_reg     <= cfg_data;
                cc20_pkg::CFG_NONCE_LOW:  nonce_lo_reg <= cfg_data;
                cc20_pkg::CFG_NONCE_HIGH: nonce_hi_reg <= cfg_data[31:0];
                default: ; // unused indexes: write dropped
            endcase
        end
    end

    // --------------------------------------------------------------
    // State
    // --------------------------------------------------------------
    cc20_pkg::state_t state_reg, state_next;

    logic [63:0]  data_reg;        // request bytes
    logic [3:0]   count_reg;       // saturated byte count
    logic         last_reg;
    logic [3:0]   done_reg, done_next;   // bytes of this request already done
    logic [63:0]  res_reg, res_next;     // result being built
    logic [511:0] ks_reg, ks_next;       // keystream, unused bytes at the bottom
    logic [5:0]   pos_reg, pos_next;     // byte position within the block
    logic [31:0]  ctr_reg, ctr_next;     // counter for the next block
    logic         ready_reg, ready_next; // ks_reg holds the block for pos_reg
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  out_data_reg;
    logic [3:0]   out_count_reg;
    logic         out_last_reg;

    cc20_pkg::core_req_t core_req;
    cc20_pkg::core_rsp_t core_rsp;

    // chunk arithmetic: bytes left in the request and in the block
    logic [3:0] rem;
    logic [6:0] avail;
    logic [3:0] take;
    logic [6:0] pos_sum;
    logic [3:0] chunk_end;

    logic accept;
    logic gen_start;
    logic chunk;
    logic out_load;

    always_comb
    begin
        rem       = count_reg - done_reg;
        avail     = 7'(cc20_pkg::BLOCK_BYTES) - {1'b0, pos_reg};
        take      = ({3'b000, rem} < avail) ? rem : avail[3:0];
        pos_sum   = {1'b0, pos_reg} + {3'b000, take};
        chunk_end = done_reg + take;
    end

    assign accept    = in_valid && (state_reg == cc20_pkg::ST_IDLE);
    assign gen_start = (state_reg == cc20_pkg::ST_APPLY) && (rem != 4'd0) && !ready_reg;
    assign chunk     = (state_reg == cc20_pkg::ST_APPLY) && (rem != 4'd0) && ready_reg;
    assign out_load  = (state_reg == cc20_pkg::ST_OUT) && (!out_valid_reg || !out_stall);

    // --------------------------------------------------------------
    // Sequencer: next state
    // --------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cc20_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cc20_pkg::ST_APPLY;
                end
            end
            cc20_pkg::ST_APPLY:
            begin
                if (rem == 4'd0)
                begin
                    state_next = cc20_pkg::ST_OUT;
                end
                else if (!ready_reg)
                begin
                    state_next = cc20_pkg::ST_GEN;
                end
            end
            cc20_pkg::ST_GEN:
            begin
                if (core_rsp.done)
                begin
                    state_next = cc20_pkg::ST_APPLY;
                end
            end
            cc20_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = cc20_pkg::ST_IDLE;
                end
            end
            default: state_next = cc20_pkg::ST_IDLE;
        endcase
    end

    // --------------------------------------------------------------
    // Sequencer: datapath and outputs
    // --------------------------------------------------------------
    always_comb
    begin
        done_next      = done_reg;
        res_next       = res_reg;
        ks_next        = ks_reg;
        pos_next       = pos_reg;
        ctr_next       = ctr_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg;

        if (accept)
        begin
            done_next = '0;
            res_next  = '0;
        end

        // block request: counter goes up as the block is started
        if (gen_start)
        begin
            ctr_next = ctr_reg + 32'd1;
        end

        if (core_rsp.done)
        begin
            ks_next    = core_rsp.block;
            ready_next = 1'b1;
        end

        // XOR one run of bytes that the current block covers
        if (chunk)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if ((4'(i) >= done_reg) && (4'(i) < chunk_end))
                begin
                    res_next[8 * i +: 8] = data_reg[8 * i +: 8]
                        ^ ks_reg[{3'(4'(i) - done_reg), 3'b000} +: 8];
                end
            end
            done_next = chunk_end;
            ks_next   = ks_reg >> {take, 3'b000};
            pos_next  = pos_sum[5:0];
            if (pos_sum[6])
            begin
                ready_next = 1'b0;
            end
        end

        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            // end of message: counter and position start afresh
            if (last_reg)
            begin
                ctr_next   = 32'd1;
                pos_next   = '0;
                ready_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cc20_pkg::ST_IDLE;
            done_reg      <= '0;
            pos_reg       <= '0;
            ctr_reg       <= 32'd1;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            pos_reg       <= pos_next;
            ctr_reg       <= ctr_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg  <= data_in;
            count_reg <= (byte_count > 4'd8) ? 4'd8 : byte_count;
            last_reg  <= last_in;
        end
        res_reg <= res_next;
        ks_reg  <= ks_next;
        if (out_load)
        begin
            out_data_reg  <= res_reg;
            out_count_reg <= count_reg;
            out_last_reg  <= last_reg;
        end
    end

    // --------------------------------------------------------------
    // Round core
    // --------------------------------------------------------------
    always_comb
    begin
        core_req.start   = gen_start;
        core_req.counter = ctr_reg;
        core_req.key     = {key3_reg, key2_reg, key1_reg, key0_reg};
        core_req.nonce   = {nonce_hi_reg, nonce_lo_reg};
    end

    cc20_core
    #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    )
    u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (core_req),
        .rsp   (core_rsp)
    );

    assign in_stall       = (state_reg != cc20_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign data_out       = out_data_reg;
    assign byte_count_out = out_count_reg;
    assign last_out       = out_last_reg;

endmodule

[hw/rtl/cc20_checker.sv]
// Port-level checker for the ChaCha20 stream cipher, bound to the top level.
// Depends on chacha20_stream_cipher_macros.svh.
`include "chacha20_stream_cipher_macros.svh"

module cc20_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] data_out,
    input logic [3:0]  byte_count_out
);

    // one request in flight: an accepted request stalls the next cycle
    `CC20_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall, "second request accepted while busy")

    `CC20_ASSERT_IMP(a_count_range, clk, rst_n, out_valid, byte_count_out <= 4'd8, "result byte count above eight")

    // bytes past the count are zero
    `CC20_ASSERT_IMP(a_pad_zero, clk, rst_n, out_valid, (byte_count_out >= 4'd8) || ((data_out >> (8 * byte_count_out)) == 64'd0), "unused result bytes not zero")

    `CC20_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(data_out), "stalled result dropped or changed")

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_out       (data_out),
    .byte_count_out (byte_count_out)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for the ChaCha20 (IETF) stream cipher top level.
// Needs cc20_pkg and the chacha20_stream_cipher RTL; drives requests with
// random gaps and stalls and checks every result against a keystream model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 5;
    // The limit covers the slowest honest run: roughly 1350 requests, each with the longest
    // gap and stall and a new block.
    localparam int CYCLE_LIMIT  = 1000000;
    // Tail after the last result: a fresh block plus an item, with margin.
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_GAP      = 18;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 221;
    localparam int MAX_BYTES    = 8;
    localparam int IDX_W        = cc20_pkg::CFG_IDX_W;

    // Register indexes past the end of the map; writes to them must be ignored.
    localparam logic [IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } cipher_out_t;

    // One directed request. Where 'fixed' is set the result is typed in
    // (want_data / want_count, last follows the request), else the model decides.
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic        fixed;
        logic [63:0] want_data;
        logic [3:0]  want_count;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // zero count: no keystream used, output cleared
        '{64'h0000000000000000, 4'd0,  1'b0, 1'b1, 64'h0, 4'd0},
        '{64'hffffffffffffffff, 4'd0,  1'b0, 1'b1, 64'h0, 4'd0},
        // data extremes, full width
        '{64'hffffffffffffffff, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h0000000000000000, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        // every short count, so the byte position walks off word alignment
        '{64'h0123456789abcdef, 4'd1,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'hfedcba9876543210, 4'd2,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h5555555555555555, 4'd3,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'haaaaaaaaaaaaaaaa, 4'd4,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h00ff00ff00ff00ff, 4'd5,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'hff00ff00ff00ff00, 4'd6,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h8000000000000001, 4'd7,  1'b0, 1'b0, 64'h0, 4'd0},
        // counts above eight saturate; the last of these straddles a block
        '{64'hdeadbeefcafef00d, 4'd9,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'hffffffffffffffff, 4'd12, 1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h0f0f0f0f0f0f0f0f, 4'd15, 1'b0, 1'b0, 64'h0, 4'd0},
        // end of message mid-block, then an empty closing request
        '{64'h1122334455667788, 4'd3,  1'b1, 1'b0, 64'h0, 4'd0},
        '{64'hffffffffffffffff, 4'd0,  1'b1, 1'b1, 64'h0, 4'd0},
        // fresh message: exactly one block of full requests, then into the next
        '{64'h0000000000000000, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'hffffffffffffffff, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h0102030405060708, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h8899aabbccddeeff, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h7f7f7f7f7f7f7f7f, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h8080808080808080, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h3c3c3c3c3c3c3c3c, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'hc3c3c3c3c3c3c3c3, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{64'h0badc0de0badc0de, 4'd5,  1'b1, 1'b0, 64'h0, 4'd0}
    };

    // ------------------------------------------------------------------
    // DUT signals; everything starts at a known value
    // ------------------------------------------------------------------
    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_we     = 1'b0;
    logic [IDX_W-1:0] cfg_index  = '0;
    logic [63:0]      cfg_data   = '0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic [63:0]      data_in    = '0;
    logic [3:0]       byte_count = '0;
    logic             last_in    = 1'b0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic [63:0]      data_out;
    logic [3:0]       byte_count_out;
    logic             last_out;

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS (cc20_pkg::DOUBLE_ROUNDS_DEF)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_in        (data_in),
        .byte_count     (byte_count),
        .last_in        (last_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data_out       (data_out),
        .byte_count_out (byte_count_out),
        .last_out       (last_out)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Keystream model: own copy of key, nonce, counter and block position
    // ------------------------------------------------------------------
    logic [63:0] key_word [4]  = '{default: '0};
    logic [63:0] nonce_lo      = '0;
    logic [31:0] nonce_hi      = '0;
    logic [31:0] ks_words [16] = '{default: '0};
    logic [31:0] mix [16]      = '{default: '0};
    logic [31:0] blk_counter   = 32'd1;
    logic [5:0]  blk_pos       = '0;
    bit          blk_ready     = 1'b0;

    cipher_out_t pending_ciphertext [$];
    cipher_out_t head;
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          msg_left = 0;
    bit          in_quiet = 1'b0;
    bit          out_quiet = 1'b0;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic chacha_qr(input int a, input int b, input int c, input int d);
        mix[a] = mix[a] + mix[b]; mix[d] = rotl32(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d]; mix[b] = rotl32(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b]; mix[d] = rotl32(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d]; mix[b] = rotl32(mix[b] ^ mix[c], 7);
    endtask

    // Build the next 64-byte block from the current key, nonce and counter.
    task automatic make_keystream_block();
        logic [31:0] init_w [16];
        init_w[0] = cc20_pkg::SIGMA_0;
        init_w[1] = cc20_pkg::SIGMA_1;
        init_w[2] = cc20_pkg::SIGMA_2;
        init_w[3] = cc20_pkg::SIGMA_3;
        for (int i = 0; i < 4; i++)
        begin
            init_w[4 + 2 * i] = key_word[i][31:0];
            init_w[5 + 2 * i] = key_word[i][63:32];
        end
        init_w[12] = blk_counter;
        init_w[13] = nonce_lo[31:0];
        init_w[14] = nonce_lo[63:32];
        init_w[15] = nonce_hi;
        for (int i = 0; i < 16; i++)
            mix[i] = init_w[i];
        for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS_DEF; r++)
        begin
            chacha_qr(0, 4, 8, 12); chacha_qr(1, 5, 9, 13);
            chacha_qr(2, 6, 10, 14); chacha_qr(3, 7, 11, 15);
            chacha_qr(0, 5, 10, 15); chacha_qr(1, 6, 11, 12);
            chacha_qr(2, 7, 8, 13); chacha_qr(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            ks_words[i] = mix[i] + init_w[i];
        blk_counter = blk_counter + 32'd1;   // wraps at 32 bits
        blk_ready   = 1'b1;
    endtask

    // XOR one request with the next keystream bytes and advance the position.
    task automatic keystream_xor(input logic [63:0] data, input logic [3:0] count,
                                 input logic last, output cipher_out_t res);
        int          n;
        logic [63:0] acc;
        logic [7:0]  ks_byte;
        n   = (count > MAX_BYTES) ? MAX_BYTES : int'(count);
        acc = '0;
        for (int i = 0; i < n; i++)
        begin
            if (!blk_ready)
                make_keystream_block();
            ks_byte = 8'(ks_words[blk_pos[5:2]] >> (8 * blk_pos[1:0]));
            acc[8 * i +: 8] = data[8 * i +: 8] ^ ks_byte;
            if (blk_pos == 6'd63)
                blk_ready = 1'b0;
            blk_pos = blk_pos + 6'd1;
        end
        if (last)
        begin
            blk_counter = 32'd1;
            blk_pos     = '0;
            blk_ready   = 1'b0;
        end
        res = '{data: acc, count: 4'(n), last: last};
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch, every one counted
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: result %0d %s: got %h, wanted %h",
                 $realtime, results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Request driver: random gap before each request, quiet stretches too.
    // Valid is only lowered when a gap is drawn, so back-to-back requests
    // never see a low/high pair of assignments in one step.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [63:0] data, input logic [3:0] count,
                                input logic last, input logic fixed,
                                input logic [63:0] want_data, input logic [3:0] want_count);
        int          gap;
        cipher_out_t res;
        if ($urandom_range(0, 31) == 0)
            in_quiet = !in_quiet;
        gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_in    <= data;
        byte_count <= count;
        last_in    <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge: the model always runs to keep its state in step
        keystream_xor(data, count, last, res);
        if (fixed)
            res = '{data: want_data, count: want_count, last: last};
        pending_ciphertext = {pending_ciphertext, res};
    endtask

    // Random request within a message stream; mostly full requests so that
    // blocks are used up, with short, empty and oversized counts mixed in.
    task automatic send_random_request();
        int         sel;
        logic [3:0] count;
        if (msg_left == 0)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
                msg_left = $urandom_range(1, 16);
            else if (sel < 95)
                msg_left = $urandom_range(17, 48);
            else
                msg_left = $urandom_range(49, 80);
        end
        sel = $urandom_range(0, 99);
        if (sel < 70)
            count = 4'd8;
        else if (sel < 88)
            count = 4'($urandom_range(1, 7));
        else if (sel < 94)
            count = 4'd0;
        else
            count = 4'($urandom_range(9, 15));
        msg_left--;
        send_request({$urandom(), $urandom()}, count, msg_left == 0, 1'b0, '0, '0);
    endtask

    // ------------------------------------------------------------------
    // Register writes: one per edge, model updated alongside
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            cc20_pkg::CFG_KEY_PART_0: key_word[0] = val;
            cc20_pkg::CFG_KEY_PART_1: key_word[1] = val;
            cc20_pkg::CFG_KEY_PART_2: key_word[2] = val;
            cc20_pkg::CFG_KEY_PART_3: key_word[3] = val;
            cc20_pkg::CFG_NONCE_LOW:  nonce_lo    = val;
            cc20_pkg::CFG_NONCE_HIGH: nonce_hi    = val[31:0];
            default: ;      // outside the map, no effect
        endcase
    endtask

    // Wait until the block has nothing in flight; messages may still be open,
    // so a new key lands mid-block and only affects the next block made.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_ciphertext.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure_phase(input int phase);
        case (phase)
            0:  // all ones everywhere, upper nonce_high bits included
                for (int i = int'(cc20_pkg::CFG_KEY_PART_0);
                     i <= int'(cc20_pkg::CFG_NONCE_HIGH); i++)
                    write_reg(IDX_W'(i), '1);
            2:
            begin
                // back to all zeros; the spare indexes must not disturb that
                for (int i = int'(cc20_pkg::CFG_KEY_PART_0);
                     i <= int'(cc20_pkg::CFG_NONCE_HIGH); i++)
                    write_reg(IDX_W'(i), '0);
                write_reg(CFG_SPARE_6, '1);
                write_reg(CFG_SPARE_7, '1);
            end
            4:
            begin
                // partial update only
                write_reg(cc20_pkg::CFG_KEY_PART_1, {$urandom(), $urandom()});
                write_reg(cc20_pkg::CFG_NONCE_LOW, {$urandom(), $urandom()});
            end
            default:
            begin
                for (int i = int'(cc20_pkg::CFG_KEY_PART_0);
                     i <= int'(cc20_pkg::CFG_NONCE_HIGH); i++)
                    write_reg(IDX_W'(i), {$urandom(), $urandom()});
                write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                          {$urandom(), $urandom()});
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall before each result, quiet stretches too
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                out_quiet = !out_quiet;
            n = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest prediction, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (pending_ciphertext.size() == 0)
                report_mismatch("unexpected result, data_out", data_out, '0);
            else
            begin
                head = pending_ciphertext.pop_front();
                if (data_out !== head.data)
                    report_mismatch("data_out", data_out, head.data);
                if (byte_count_out !== head.count)
                    report_mismatch("byte_count_out", 64'(byte_count_out), 64'(head.count));
                if (last_out !== head.last)
                    report_mismatch("last_out", 64'(last_out), 64'(head.last));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests under the reset key and nonce (all zero)
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_request(DIRECTED[r].data, DIRECTED[r].count, DIRECTED[r].last,
                         DIRECTED[r].fixed, DIRECTED[r].want_data, DIRECTED[r].want_count);

        // random message streams, with a register change between phases
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            configure_phase(p);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_random_request();
        end

        in_valid <= 1'b0;
        while (pending_ciphertext.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
